// ===== hw/rtl/ssi_pkg.sv =====
// ----------------------------------------------------------------------------
// ssi_pkg: shared types and constants for the sorted stack
// Request and status codes, stored word type, cell control struct and the
// conversion helpers between channel fields and stored words.
// ----------------------------------------------------------------------------
package ssi_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int IDX_W      = $clog2(DEPTH);

   typedef logic signed [DATA_WIDTH-1:0] word_type;
   typedef logic [CNT_W-1:0]             count_type;
   typedef logic [IDX_W-1:0]             index_type;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_POP    = 2'd1,
      MODE_READ   = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic     ins_en;
      word_type word;
   } cell_ctl_type;

   // low DATA_WIDTH bits of the 32-bit request value (zero fill above 32)
   function automatic word_type to_word(input logic [31:0] v);
      logic [63:0] ext;
      ext = 64'(v);
      return ext[DATA_WIDTH-1:0];
   endfunction

   // sign-extend a stored word, keep 32 bits
   function automatic logic [31:0] to_data_field(input word_type w);
      logic [63:0] ext;
      ext = 64'(w);
      return ext[31:0];
   endfunction

   function automatic logic [4:0] to_occupancy(input count_type c);
      logic [7:0] ext;
      ext = 8'(c);
      return ext[4:0];
   endfunction

endpackage

// ===== hw/rtl/ssi_channels.sv =====
// ----------------------------------------------------------------------------
// ssi_channels: request and response channel interfaces
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ssi_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] value;
   logic [3:0]  position;

   modport source (output valid, mode, value, position, input ready);
   modport sink   (input valid, mode, value, position, output ready);
endinterface

interface ssi_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   logic [1:0]  status;
   logic [4:0]  occupancy;

   modport source (output valid, data, status, occupancy, input ready);
   modport sink   (input valid, data, status, occupancy, output ready);
endinterface

// ===== hw/rtl/ssi_cell.sv =====
// ----------------------------------------------------------------------------
// ssi_cell: one slot of the sorted chain
// Holds one word; on insert it keeps, takes the new word, or takes the word
// of the cell below when that one shifts up.
// ----------------------------------------------------------------------------
module ssi_cell (
   input  logic                 clock,
   input  ssi_pkg::cell_ctl_type ctl,
   input  logic                 occupied,   // slot below the fill level
   input  logic                 at_fill,    // first free slot
   input  ssi_pkg::word_type    prev_word,
   input  logic                 prev_gt,
   output ssi_pkg::word_type    word,
   output logic                 gt
);

   ssi_pkg::word_type word_ff, word_in;

   // stored word strictly greater than the new one
   assign gt = occupied && (word_ff > ctl.word);

   always_comb begin
      word_in = word_ff;
      if (ctl.ins_en) begin
         if (prev_gt) begin
            word_in = prev_word;
         end else if (gt || at_fill) begin
            word_in = ctl.word;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ===== hw/rtl/sorted_stack_insert.sv =====
// ----------------------------------------------------------------------------
// sorted_stack_insert: bounded stack kept sorted ascending, top is the maximum
// Row of compare-and-shift cells with one registered response stage.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan carries mode (insert, pop, read), value and position. Every
//    request gives exactly one transfer on rsp_chan: data, status, occupancy.
//  - Insert: every cell compares its word against the new value in the same
//    cycle; greater cells shift up one slot and the first of them takes the
//    new value. When full, the largest of the stored words and the new one is
//    dropped and status reports full.
//  - Pop returns the top word; read returns the word at position from the
//    bottom. Both use one read mux over the cells.
//  - Response: registered; valid in the cycle after the request transfer.
//  - Throughput: one request per cycle while responses are taken; the chain
//    updates on the request transfer and the response register frees up in the cycle it is taken.
//  - Stall: while a response waits and rsp_chan.ready is low, req_chan.ready
//    is low and the state holds.
//  - Reset: synchronous, clears the entry count and the response valid. Cell
//    contents are not cleared; only slots below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_stack_insert (
   input  logic             clock,
   input  logic             reset,
   ssi_req_if.sink          req_chan,
   ssi_rsp_if.source        rsp_chan
);

   localparam int DEPTH = ssi_pkg::DEPTH;

   ssi_pkg::count_type    count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_data_ff, rsp_data_in;
   ssi_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [4:0]            rsp_occ_ff, rsp_occ_in;

   logic                  req_xfer;
   ssi_pkg::mode_type     mode;
   ssi_pkg::word_type     new_word;
   ssi_pkg::cell_ctl_type ctl;

   ssi_pkg::word_type     cell_word [DEPTH];
   logic                  cell_gt   [DEPTH];
   logic                  full;
   ssi_pkg::count_type    count_dec;
   ssi_pkg::index_type    rd_idx;
   ssi_pkg::word_type     rd_word;
   logic                  pos_in_range;

   // accept outside reset whenever the response register is empty or drains
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign mode           = ssi_pkg::mode_type'(req_chan.mode);
   assign new_word       = ssi_pkg::to_word(req_chan.value);

   assign ctl.ins_en = req_xfer && (mode == ssi_pkg::MODE_INSERT);
   assign ctl.word   = new_word;

   // the chain: each cell sees its lower neighbor's word and compare flag
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic              occupied;
      logic              at_fill;
      ssi_pkg::word_type prev_word;
      logic              prev_gt;

      assign occupied = 32'(i) < 32'(count_ff);
      assign at_fill  = 32'(i) == 32'(count_ff);

      if (i == 0) begin : g_bottom
         assign prev_word = new_word;
         assign prev_gt   = 1'b0;
      end else begin : g_upper
         assign prev_word = cell_word[i-1];
         assign prev_gt   = cell_gt[i-1];
      end

      ssi_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .occupied  (occupied),
         .at_fill   (at_fill),
         .prev_word (prev_word),
         .prev_gt   (prev_gt),
         .word      (cell_word[i]),
         .gt        (cell_gt[i])
      );
   end

   assign full      = 32'(count_ff) == DEPTH;
   assign count_dec = ssi_pkg::count_type'(count_ff - ssi_pkg::count_type'(1));

   // single read port: top for pop, position for read
   assign rd_idx = (mode == ssi_pkg::MODE_POP) ? count_dec[ssi_pkg::IDX_W-1:0]
                                               : ssi_pkg::index_type'(req_chan.position);

   always_comb begin
      rd_word = '0;
      if (32'(rd_idx) < DEPTH) begin
         rd_word = cell_word[rd_idx];
      end
   end

   assign pos_in_range = 8'(req_chan.position) < 8'(count_ff);

   always_comb begin
      count_in      = count_ff;
      rsp_data_in   = '0;
      rsp_status_in = ssi_pkg::ST_OK;
      case (mode)
         ssi_pkg::MODE_INSERT: begin
            // full: either the new word (no greater cell) or the old top drops
            if (full) begin
               rsp_status_in = ssi_pkg::ST_FULL;
            end else begin
               count_in = ssi_pkg::count_type'(count_ff + ssi_pkg::count_type'(1));
            end
         end
         ssi_pkg::MODE_POP: begin
            if (count_ff == '0) begin
               rsp_status_in = ssi_pkg::ST_EMPTY;
            end else begin
               count_in    = count_dec;
               rsp_data_in = ssi_pkg::to_data_field(rd_word);
            end
         end
         ssi_pkg::MODE_READ: begin
            if (pos_in_range) begin
               rsp_data_in = ssi_pkg::to_data_field(rd_word);
            end else begin
               rsp_status_in = ssi_pkg::ST_RANGE;
            end
         end
         default: begin
            // unused code: no state change, ok status
         end
      endcase
      rsp_occ_in = ssi_pkg::to_occupancy(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.data      = rsp_data_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.occupancy = rsp_occ_ff;

endmodule

// ===== hw/rtl/ssi_checker.sv =====
// ----------------------------------------------------------------------------
// ssi_checker: port-level checks for sorted_stack_insert
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module ssi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_data,
   input logic [1:0]  rsp_status,
   input logic [4:0]  rsp_occupancy
);

   // a pending response is held until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped before transfer");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request gave no response");

   a_free_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response stage");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ssi_pkg::ST_EMPTY)) |->
         ((rsp_data == 32'd0) && (rsp_occupancy == 5'd0)))
      else $error("empty status with data or nonzero occupancy");

endmodule

bind sorted_stack_insert ssi_checker u_ssi_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_data      (rsp_chan.data),
   .rsp_status    (rsp_chan.status),
   .rsp_occupancy (rsp_chan.occupancy)
);
